// ===== rtl/cpu_alu_with_flags_top_defines.svh =====
// Assertion macros shared by the ALU RTL.
`ifndef CPU_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// Checked only while out of reset.
`define CALF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define CALF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/calf_pkg.sv =====
package calf_pkg;

    // Operation codes
    localparam logic [4:0] FUNC_INC   = 5'd0;
    localparam logic [4:0] FUNC_DEC   = 5'd1;
    localparam logic [4:0] FUNC_ADD16 = 5'd2;
    localparam logic [4:0] FUNC_ADD   = 5'd3;
    localparam logic [4:0] FUNC_ADC   = 5'd4;
    localparam logic [4:0] FUNC_SUB   = 5'd5;
    localparam logic [4:0] FUNC_SBC   = 5'd6;
    localparam logic [4:0] FUNC_AND   = 5'd7;
    localparam logic [4:0] FUNC_XOR   = 5'd8;
    localparam logic [4:0] FUNC_OR    = 5'd9;
    localparam logic [4:0] FUNC_CP    = 5'd10;
    localparam logic [4:0] FUNC_SRL   = 5'd11;
    localparam logic [4:0] FUNC_RR    = 5'd12;
    localparam logic [4:0] FUNC_RLC   = 5'd13;
    localparam logic [4:0] FUNC_RRC   = 5'd14;
    localparam logic [4:0] FUNC_RL    = 5'd15;
    localparam logic [4:0] FUNC_BIT   = 5'd16;
    localparam logic [4:0] FUNC_SLA   = 5'd17;
    localparam logic [4:0] FUNC_SRA   = 5'd18;
    localparam logic [4:0] FUNC_SWAP  = 5'd19;
    localparam logic [4:0] FUNC_SET   = 5'd20;
    localparam logic [4:0] FUNC_RES   = 5'd21;

    // Flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [4:0]  func;
        logic [15:0] lhs;
        logic [15:0] rhs;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } calf_in_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
        logic        writes_result;
    } calf_out_t;

    // Pack Z, N, H, C into a flag nibble
    function automatic logic [3:0] znhc(input logic z, input logic n,
                                        input logic h, input logic c);
        return {z, n, h, c};
    endfunction

endpackage

// ===== rtl/calf_in_reg.sv =====
module calf_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  calf_pkg::calf_in_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output calf_pkg::calf_in_t q_data
);
    import calf_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    calf_in_t data_reg;

    // Take a new item whenever the register is empty or drains this cycle
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Operand register, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ===== rtl/calf_alu.sv =====
module calf_alu (
    input  calf_pkg::calf_in_t  op,
    output calf_pkg::calf_out_t res
);
    import calf_pkg::*;

    logic [7:0]  a;
    logic [7:0]  v;
    logic        c;
    logic        cin_add;
    logic        cin_sub;
    logic [8:0]  sum9;
    logic [4:0]  sum_lo;
    logic [8:0]  dif9;
    logic [4:0]  dif_lo;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  bit_mask;

    assign a = op.lhs[7:0];
    assign v = op.rhs[7:0];
    assign c = op.flags_in[FLAG_C];

    // Carry in only for the with-carry forms
    assign cin_add = (op.func == FUNC_ADC) ? c : 1'b0;
    assign cin_sub = (op.func == FUNC_SBC) ? c : 1'b0;

    // Shared adders; bit 8 / bit 4 give carry or borrow out, bit 16 / bit 12 for ADD16
    assign sum9   = {1'b0, a} + {1'b0, v} + {8'b0, cin_add};
    assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, cin_add};
    assign dif9   = {1'b0, a} - {1'b0, v} - {8'b0, cin_sub};
    assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, cin_sub};
    assign sum17  = {1'b0, op.lhs} + {1'b0, op.rhs};
    assign sum13  = {1'b0, op.lhs[11:0]} + {1'b0, op.rhs[11:0]};
    assign inc8   = v + 8'd1;
    assign dec8   = v - 8'd1;
    assign bit_mask = 8'd1 << op.bit_index;

    // Operation select
    always_comb begin
        logic [7:0] r8;
        logic [3:0] f;
        logic       wr;
        logic       wide;
        r8   = 8'd0;
        f    = op.flags_in;
        wr   = 1'b1;
        wide = 1'b0;
        unique case (op.func)
            FUNC_INC: begin
                r8 = inc8;
                f  = znhc(inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, c);
            end
            FUNC_DEC: begin
                r8 = dec8;
                f  = znhc(dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF, c);
            end
            FUNC_ADD16: begin
                wide = 1'b1;
                f    = znhc(op.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]);
            end
            FUNC_ADD, FUNC_ADC: begin
                r8 = sum9[7:0];
                f  = znhc(sum9[7:0] == 8'd0, 1'b0, sum_lo[4], sum9[8]);
            end
            FUNC_SUB, FUNC_SBC, FUNC_CP: begin
                r8 = dif9[7:0];
                f  = znhc(dif9[7:0] == 8'd0, 1'b1, dif_lo[4], dif9[8]);
                wr = (op.func != FUNC_CP);
            end
            FUNC_AND: begin
                r8 = a & v;
                f  = znhc((a & v) == 8'd0, 1'b0, 1'b1, 1'b0);
            end
            FUNC_XOR: begin
                r8 = a ^ v;
                f  = znhc((a ^ v) == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            FUNC_OR: begin
                r8 = a | v;
                f  = znhc((a | v) == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            FUNC_SRL: begin
                r8 = {1'b0, v[7:1]};
                f  = znhc(v[7:1] == 7'd0, 1'b0, 1'b0, v[0]);
            end
            FUNC_RR: begin
                r8 = {c, v[7:1]};
                f  = znhc({c, v[7:1]} == 8'd0, 1'b0, 1'b0, v[0]);
            end
            FUNC_RLC: begin
                r8 = {v[6:0], v[7]};
                f  = znhc(v == 8'd0, 1'b0, 1'b0, v[7]);
            end
            FUNC_RRC: begin
                r8 = {v[0], v[7:1]};
                f  = znhc(v == 8'd0, 1'b0, 1'b0, v[0]);
            end
            FUNC_RL: begin
                r8 = {v[6:0], c};
                f  = znhc({v[6:0], c} == 8'd0, 1'b0, 1'b0, v[7]);
            end
            FUNC_BIT: begin
                wr = 1'b0;
                f  = znhc(!v[op.bit_index], 1'b0, 1'b1, c);
            end
            FUNC_SLA: begin
                r8 = {v[6:0], 1'b0};
                f  = znhc(v[6:0] == 7'd0, 1'b0, 1'b0, v[7]);
            end
            FUNC_SRA: begin
                r8 = {v[7], v[7:1]};
                f  = znhc(v[7:1] == 7'd0 && !v[7], 1'b0, 1'b0, v[0]);
            end
            FUNC_SWAP: begin
                r8 = {v[3:0], v[7:4]};
                f  = znhc(v == 8'd0, 1'b0, 1'b0, 1'b0);
            end
            FUNC_SET: begin
                r8 = v | bit_mask;
            end
            FUNC_RES: begin
                r8 = v & ~bit_mask;
            end
            default: begin
                // unused codes: no write, flags pass through
                wr = 1'b0;
            end
        endcase
        res.result        = wide ? sum17[15:0] : {8'd0, r8};
        res.flags_out     = f;
        res.writes_result = wr;
    end

endmodule

// ===== rtl/calf_out_reg.sv =====
module calf_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               d_valid,
    output logic               d_ready,
    input  calf_pkg::calf_out_t d_data,
    output logic               m_valid,
    input  logic               m_ready,
    output calf_pkg::calf_out_t m_data
);
    import calf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    calf_out_t data_reg;

    // Result register refills in the same cycle it is drained
    assign d_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (d_valid && d_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_valid && d_ready) begin
            data_reg <= d_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/cpu_alu_with_flags_top.sv =====
// 8-bit ALU with Z/N/H/C flags and a 16-bit add. One item per clock sustained
// while m_ready holds; each result passes through the operand register and
// then the result register, with the whole operation done by single-pass
// logic between them. Both registers refill in the cycle they
// drain, so s_ready drops only while a result waits on m_ready and the
// operand register is full behind it.
`include "cpu_alu_with_flags_top_defines.svh"

module cpu_alu_with_flags_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  calf_pkg::calf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output calf_pkg::calf_out_t m_data
);
    import calf_pkg::*;

    logic      op_valid;
    logic      op_ready;
    calf_in_t  op_data;
    calf_out_t alu_res;

    // Operand register
    calf_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (op_valid),
        .q_ready (op_ready),
        .q_data  (op_data)
    );

    // Operation logic
    calf_alu u_alu (
        .op  (op_data),
        .res (alu_res)
    );

    // Result register
    calf_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (op_valid),
        .d_ready (op_ready),
        .d_data  (alu_res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Checks
    `CALF_ASSERT_RST(a_rst_empty, !aresetn |=> !m_valid && !op_valid, "valid set after reset")
    `CALF_ASSERT(a_take_lands, s_valid && s_ready |=> op_valid, "accepted item lost")
    `CALF_ASSERT(a_op_hold, op_valid && !op_ready |=> op_valid && $stable(op_data), "operand stall")
    `CALF_ASSERT(a_no_wr, op_valid && (op_data.func == FUNC_CP || op_data.func == FUNC_BIT) |-> !alu_res.writes_result, "cp/bit write")
    `CALF_ASSERT(a_hi_zero, op_valid && op_data.func != FUNC_ADD16 |-> alu_res.result[15:8] == 8'd0, "upper byte set")

endmodule
